/* hdl/rdcc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB digit color controller package
// Request codes, selector codes, color constants and small helpers shared by
// the color controller.
// ----------------------------------------------------------------------------
package rdcc_pkg;

   // 24-bit color: red in 23:16, green in 15:8, blue in 7:0.
   typedef logic [23:0] color_type;

   // Request codes.
   localparam logic [2:0] REQ_FADE_TICK   = 3'd0;
   localparam logic [2:0] REQ_PRESET      = 3'd1;
   localparam logic [2:0] REQ_VALUE_STEP  = 3'd2;
   localparam logic [2:0] REQ_FADE_MODE   = 3'd3;
   localparam logic [2:0] REQ_MIX_STEP    = 3'd4;
   localparam logic [2:0] REQ_WRITE_COLOR = 3'd5;

   // Group codes.
   localparam logic [1:0] GRP_STATUS = 2'd3;

   // Channel codes.
   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   // Write target codes beyond the single digits.
   localparam logic [2:0] TGT_ALL_DIGITS = 3'd6;
   localparam logic [2:0] TGT_STATUS     = 3'd7;

   // Fade mode codes.
   localparam logic [1:0] FADE_OFF    = 2'd0;
   localparam logic [1:0] FADE_ALL    = 2'd1;
   localparam logic [1:0] FADE_ROTATE = 2'd2;

   // Fade phase codes.
   localparam logic [1:0] PHASE_RG = 2'd0;
   localparam logic [1:0] PHASE_GB = 2'd1;
   localparam logic [1:0] PHASE_BR = 2'd2;

   // Level and counter limits.
   localparam logic [7:0] LEVEL_MAX   = 8'd255;
   localparam logic [7:0] LEVEL_MIN   = 8'd0;
   localparam logic [2:0] PRESET_LAST = 3'd6;
   localparam logic [2:0] SLOT_LAST   = 3'd5;
   localparam logic [2:0] PRESET_RST  = 3'd1;

   // Mix step increments.
   localparam logic [7:0] MIX_RED_INC   = 8'd50;
   localparam logic [7:0] MIX_GREEN_INC = 8'd100;
   localparam logic [7:0] MIX_BLUE_INC  = 8'd200;

   // Reset colors.
   localparam color_type DIGIT_RST_COLOR = 24'hFF0000;

   // Default rounding step for value steps.
   localparam int unsigned STEP_MIX_DEFAULT = 5;

   // Preset color for an index: seven on/off mixes of the three channels.
   function automatic color_type preset_color(input logic [2:0] idx);
      logic [2:0] mix;
      begin
         case (idx)
            3'd0:    mix = 3'b100;
            3'd1:    mix = 3'b010;
            3'd2:    mix = 3'b001;
            3'd3:    mix = 3'b110;
            3'd4:    mix = 3'b101;
            3'd5:    mix = 3'b011;
            3'd6:    mix = 3'b111;
            default: mix = 3'b100;
         endcase
         preset_color = {{8{mix[2]}}, {8{mix[1]}}, {8{mix[0]}}};
      end
   endfunction

   // Read one channel of a color.
   function automatic logic [7:0] get_chan(input color_type color, input logic [1:0] ch);
      begin
         case (ch)
            CHAN_RED:   get_chan = color[23:16];
            CHAN_GREEN: get_chan = color[15:8];
            CHAN_BLUE:  get_chan = color[7:0];
            default:    get_chan = 8'd0;
         endcase
      end
   endfunction

   // Replace one channel of a color.
   function automatic color_type set_chan(input color_type color, input logic [1:0] ch,
                                          input logic [7:0] v);
      color_type res;
      begin
         res = color;
         case (ch)
            CHAN_RED:   res[23:16] = v;
            CHAN_GREEN: res[15:8]  = v;
            CHAN_BLUE:  res[7:0]   = v;
            default:    res        = color;
         endcase
         set_chan = res;
      end
   endfunction

endpackage

/* hdl/rgb_digit_color_controller.sv */
// ----------------------------------------------------------------------------
// RGB digit color controller
// Holds the colors of six display digits and a status LED and updates them for
// each request item in turn: fade ticks, preset cycling, value steps, fade
// mode, mix steps and direct writes.
// ----------------------------------------------------------------------------
// Usage:
// Request items arrive on the req_ channel; req_tuser carries the request
// code and req_tdata the operands. Each request item yields exactly one
// result item on the rsp_ channel with all seven colors and the fade mode as
// they stand after that request.
// An accepted item is held in the input register; the update logic then writes
// the color state and the result register together, so a result is registered
// once its item leaves the input register. One item per cycle is sustained
// while the receiver keeps rsp_tready high; the rate is set by the single update
// pass between the input register and the result register.
// Reset sets all digits to red, the status LED to black, every preset index
// to one, the fade off with its ramps at their start, and clears the mix.
// When the receiver holds rsp_tready low, the result register keeps its item
// and one more request item waits in the input register; req_tready then
// drops until the result is taken.
// ----------------------------------------------------------------------------
module rgb_digit_color_controller
   import rdcc_pkg::*;
#(
   parameter int unsigned STEP_MIX = STEP_MIX_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tuser: req_type[2:0]
   input  logic [2:0]   req_tuser,
   // tdata: group[1:0], direction[2], channel[4:3], step_size[12:5],
   //        target[15:13], red[23:16], green[31:24], blue[39:32]
   input  logic [39:0]  req_tdata,
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: digit0_color[23:0], digit1_color[47:24], digit2_color[71:48],
   //        digit3_color[95:72], digit4_color[119:96], digit5_color[143:120],
   //        status_color[167:144], fade_mode[169:168], zero fill[175:170]
   output logic [175:0] rsp_tdata
);

   localparam int unsigned NUM_DIGITS = 6;
   localparam int unsigned NUM_GROUPS = 4;
   localparam int unsigned LUT_DEPTH  = 256;

   // Handshake and pipeline control.
   logic         in_valid_ff, in_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         out_open;
   logic         step_fire;
   logic         req_fire;

   // Input register.
   logic [2:0]   req_type_ff;
   logic [39:0]  req_data_ff;

   // Result register.
   logic [175:0] rsp_data_ff, rsp_data_in;

   // Color state.
   color_type    digit_ff [NUM_DIGITS];
   color_type    digit_in [NUM_DIGITS];
   color_type    status_ff, status_in;
   logic [2:0]   preset_ff [NUM_GROUPS];
   logic [2:0]   preset_in [NUM_GROUPS];
   logic [1:0]   fade_sel_ff, fade_sel_in;
   logic [1:0]   phase_ff, phase_in;
   logic [7:0]   rise_ff, rise_in;
   logic [7:0]   fall_ff, fall_in;
   color_type    mix_ff, mix_in;
   logic [2:0]   slot_ff, slot_in;

   // Fields of the registered item.
   logic [1:0]   f_group;
   logic         f_dir;
   logic [1:0]   f_chan;
   logic [7:0]   f_step;
   logic [2:0]   f_target;
   color_type    f_color;

   // Per-request intermediate values.
   logic [2:0]   preset_cur, preset_next;
   color_type    preset_col;
   logic [7:0]   chan_cur, chan_sum, chan_round;
   logic [7:0]   rise_step, fall_step;
   logic         ramp_wrap;
   logic [7:0]   fade_r, fade_g, fade_b;
   logic [2:0]   slot_next;
   color_type    mix_next;

   // Rounding table: each level rounded down to a multiple of STEP_MIX.
   logic [7:0]   round_lut [LUT_DEPTH];

   for (genvar gi = 0; gi < LUT_DEPTH; gi++) begin : g_round
      assign round_lut[gi] = 8'(gi - (gi % STEP_MIX));
   end

   // The result register frees up when empty or when its item is taken.
   assign out_open   = !rsp_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && out_open;
   assign req_tready = !in_valid_ff || out_open;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Unpack the registered item.
   assign f_group  = req_data_ff[1:0];
   assign f_dir    = req_data_ff[2];
   assign f_chan   = req_data_ff[4:3];
   assign f_step   = req_data_ff[12:5];
   assign f_target = req_data_ff[15:13];
   assign f_color  = {req_data_ff[23:16], req_data_ff[31:24], req_data_ff[39:32]};

   // Preset index step with wrap inside the seven presets.
   assign preset_cur = preset_ff[f_group];

   always_comb begin
      if (f_dir) begin
         preset_next = (preset_cur >= PRESET_LAST) ? 3'd0 : preset_cur + 3'd1;
      end else begin
         preset_next = (preset_cur == 3'd0 || preset_cur > PRESET_LAST) ?
                       PRESET_LAST : preset_cur - 3'd1;
      end
   end

   assign preset_col = preset_color(preset_next);

   // Value step on the status channel, wrapped to 8 bits, then rounded down.
   assign chan_cur   = get_chan(status_ff, f_chan);
   assign chan_sum   = f_dir ? chan_cur + f_step : chan_cur - f_step;
   assign chan_round = round_lut[chan_sum];

   // Fade ramps: rise saturates high, fall saturates low, both reload together.
   assign rise_step = (rise_ff < LEVEL_MAX) ? rise_ff + 8'd1 : rise_ff;
   assign fall_step = (fall_ff > LEVEL_MIN) ? fall_ff - 8'd1 : fall_ff;
   assign ramp_wrap = (fall_step == LEVEL_MIN) && (rise_step == LEVEL_MAX);

   // Mix step: advance the three levels and the slot.
   assign mix_next  = {mix_ff[23:16] + MIX_RED_INC, mix_ff[15:8] + MIX_GREEN_INC,
                       mix_ff[7:0] + MIX_BLUE_INC};
   assign slot_next = (slot_ff >= SLOT_LAST) ? 3'd0 : slot_ff + 3'd1;

   // Fade color for the phase after this tick.
   always_comb begin
      case (phase_in)
         PHASE_GB: begin
            fade_r = 8'd0;
            fade_g = fall_in;
            fade_b = rise_in;
         end
         PHASE_BR: begin
            fade_r = rise_in;
            fade_g = 8'd0;
            fade_b = fall_in;
         end
         default: begin
            fade_r = fall_in;
            fade_g = rise_in;
            fade_b = 8'd0;
         end
      endcase
   end

   // Fade ramp and phase update, active only on a fade tick with fade on.
   always_comb begin
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      phase_in = phase_ff;
      if (req_type_ff == REQ_FADE_TICK && fade_sel_ff != FADE_OFF) begin
         if (ramp_wrap) begin
            rise_in  = LEVEL_MIN;
            fall_in  = LEVEL_MAX;
            phase_in = (phase_ff >= PHASE_BR) ? PHASE_RG : phase_ff + 2'd1;
         end else begin
            rise_in = rise_step;
            fall_in = fall_step;
         end
      end
   end

   // Next state of the colors, presets, fade mode and mix.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digit_in[i] = digit_ff[i];
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
         preset_in[g] = preset_ff[g];
      end
      status_in   = status_ff;
      fade_sel_in = fade_sel_ff;
      mix_in      = mix_ff;
      slot_in     = slot_ff;

      case (req_type_ff)
         REQ_FADE_TICK: begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
               if (fade_sel_ff == FADE_ALL) begin
                  digit_in[i] = {fade_r, fade_g, fade_b};
               end else if (fade_sel_ff == FADE_ROTATE) begin
                  case (i / 2)
                     0:       digit_in[i] = {fade_r, fade_g, fade_b};
                     1:       digit_in[i] = {fade_g, fade_b, fade_r};
                     default: digit_in[i] = {fade_b, fade_r, fade_g};
                  endcase
               end
            end
         end
         REQ_PRESET: begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
               if (f_group == 2'(g)) begin
                  preset_in[g] = preset_next;
               end
            end
            if (f_group == GRP_STATUS) begin
               status_in = preset_col;
            end else begin
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  if (f_group == 2'(i / 2)) begin
                     digit_in[i] = preset_col;
                  end
               end
            end
         end
         REQ_VALUE_STEP: begin
            if (f_chan == CHAN_RED || f_chan == CHAN_GREEN || f_chan == CHAN_BLUE) begin
               status_in = set_chan(status_ff, f_chan, chan_round);
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  if (f_group != GRP_STATUS && f_group == 2'(i / 2)) begin
                     digit_in[i] = set_chan(digit_ff[i], f_chan, chan_round);
                  end
               end
            end
         end
         REQ_FADE_MODE: begin
            fade_sel_in = (fade_sel_ff >= FADE_ROTATE) ? FADE_OFF : fade_sel_ff + 2'd1;
         end
         REQ_MIX_STEP: begin
            mix_in  = mix_next;
            slot_in = slot_next;
            for (int i = 0; i < NUM_DIGITS; i++) begin
               if (slot_next == 3'(i)) begin
                  digit_in[i] = mix_next;
               end
            end
         end
         REQ_WRITE_COLOR: begin
            if (f_target == TGT_STATUS) begin
               status_in = f_color;
            end else begin
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  if (f_target == TGT_ALL_DIGITS || f_target == 3'(i)) begin
                     digit_in[i] = f_color;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result item: the whole state after this request.
   assign rsp_data_in = {6'd0, fade_sel_in, status_in, digit_in[5], digit_in[4],
                         digit_in[3], digit_in[2], digit_in[1], digit_in[0]};

   // Handshake flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff <= req_tuser;
         req_data_ff <= req_tdata;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Color state, updated as each item passes to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_ff[i] <= DIGIT_RST_COLOR;
         end
         for (int g = 0; g < NUM_GROUPS; g++) begin
            preset_ff[g] <= PRESET_RST;
         end
         status_ff   <= '0;
         fade_sel_ff <= FADE_OFF;
         phase_ff    <= PHASE_RG;
         rise_ff     <= LEVEL_MIN;
         fall_ff     <= LEVEL_MAX;
         mix_ff      <= '0;
         slot_ff     <= '0;
      end else if (step_fire) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_ff[i] <= digit_in[i];
         end
         for (int g = 0; g < NUM_GROUPS; g++) begin
            preset_ff[g] <= preset_in[g];
         end
         status_ff   <= status_in;
         fade_sel_ff <= fade_sel_in;
         phase_ff    <= phase_in;
         rise_ff     <= rise_in;
         fall_ff     <= fall_in;
         mix_ff      <= mix_in;
         slot_ff     <= slot_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A waiting item stays in the input register while the result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |=> in_valid_ff)
      else $error("input item dropped while the result was stalled");

   // The fade mode in a result is never the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[169:168] != 2'd3)
      else $error("fade mode out of range in result");

   // Preset indexes stay within the seven presets.
   assert property (@(posedge clock) disable iff (reset)
      preset_ff[0] <= PRESET_LAST && preset_ff[1] <= PRESET_LAST &&
      preset_ff[2] <= PRESET_LAST && preset_ff[3] <= PRESET_LAST)
      else $error("preset index out of range");

   // Mix slot and fade phase stay within their ranges.
   assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST && phase_ff <= PHASE_BR)
      else $error("mix slot or fade phase out of range");

endmodule
